// ===== rtl/core/kmce_pkg.sv =====
// ----------------------------------------------------------------------------
// kmce_pkg
// Shared codes and field widths of the k-means cluster engine.
// ----------------------------------------------------------------------------
package kmce_pkg;

   // value width (signed Q8.8)
   localparam int VALUE_W = 16;

   // field widths of the request and response items
   localparam int CMD_W     = 3;
   localparam int ROW_W     = 10;
   localparam int COL_W     = 3;
   localparam int KIND_W    = 2;
   localparam int CLUSTER_W = 5;
   localparam int ROUNDS_W  = 16;

   // register widths
   localparam int NSAMP_W = 11;
   localparam int NCENT_W = 5;
   localparam int NATTR_W = 4;

   // configuration port
   localparam int PADDR_W = 5;
   localparam int PDATA_W = 32;

   typedef logic [CMD_W-1:0]  cmd_type;
   typedef logic [KIND_W-1:0] kind_type;
   typedef logic [2:0]        reg_idx_type;

   // commands
   localparam cmd_type CMD_LOAD_SAMPLE   = 3'd0;
   localparam cmd_type CMD_LOAD_CENTROID = 3'd1;
   localparam cmd_type CMD_RUN           = 3'd2;
   localparam cmd_type CMD_READ_ASSIGN   = 3'd3;
   localparam cmd_type CMD_READ_CENTROID = 3'd4;

   // response kinds
   localparam kind_type KIND_RUN_DONE = 2'd0;
   localparam kind_type KIND_ASSIGN   = 2'd1;
   localparam kind_type KIND_CENTROID = 2'd2;

   // register indexes
   localparam reg_idx_type REG_NUM_SAMPLES   = 3'd0;
   localparam reg_idx_type REG_NUM_CENTROIDS = 3'd1;
   localparam reg_idx_type REG_NUM_ATTRS     = 3'd2;
   localparam reg_idx_type REG_MAX_ROUNDS    = 3'd3;
   localparam reg_idx_type REG_STOP_COUNT    = 3'd4;

endpackage

// ===== rtl/core/kmeans_cluster_engine_core.sv =====
// ----------------------------------------------------------------------------
// kmeans_cluster_engine_core
// Lloyd k-means engine: loads samples and centroids, runs assignment and
// update rounds on one shared squarer, accumulator and serial divider.
// ----------------------------------------------------------------------------
// loads write their store at the transfer; reads answer from state S_RESP,
//   after S_RDW, waiting there while the response channel stalls
// each round clears the MAX_CLUSTERS*MAX_ATTRS member sums, assigns every sample
//   and divides non-empty centroids' sums (SUM_W = 27 by default) on the divider
// one item at a time: req_stall is high while an item is in work
// synchronous reset clears control state; sample and centroid stores hold
//   undefined data until written, assignments read as 0 until assigned

module kmeans_cluster_engine_core #(
   parameter int MAX_SAMPLES  = 1024,
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_ATTRS    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kmce_pkg::CMD_W-1:0]        req_cmd,
   input  logic [kmce_pkg::ROW_W-1:0]        req_row,
   input  logic [kmce_pkg::COL_W-1:0]        req_column,
   input  logic signed [kmce_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kmce_pkg::KIND_W-1:0]       rsp_kind,
   output logic [kmce_pkg::CLUSTER_W-1:0]    rsp_cluster,
   output logic signed [kmce_pkg::VALUE_W-1:0] rsp_centroid_value,
   output logic [kmce_pkg::ROUNDS_W-1:0]     rsp_rounds_run,
   output logic                              rsp_converged,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [kmce_pkg::PADDR_W-1:0]      csr_paddr,
   input  logic [kmce_pkg::PDATA_W-1:0]      csr_pwdata,
   output logic [kmce_pkg::PDATA_W-1:0]      csr_prdata,
   output logic                              csr_pready
);
   import kmce_pkg::*;

   localparam int VW     = VALUE_W;
   localparam int SW     = $clog2(MAX_SAMPLES);
   localparam int CW     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int AW     = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
   localparam int SA_N   = MAX_SAMPLES * MAX_ATTRS;
   localparam int SA_W   = $clog2(SA_N);
   localparam int CA_N   = MAX_CLUSTERS * MAX_ATTRS;
   localparam int CA_W   = $clog2(CA_N);
   localparam int CI_W   = $clog2(MAX_CLUSTERS + 1);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = VW + $clog2(MAX_SAMPLES) + 1;
   localparam int IS_W   = $clog2(MAX_SAMPLES * MAX_CLUSTERS + 1);
   localparam int P_W    = 2 * (VW + 1);
   localparam int D_W    = P_W + AW;
   localparam int DVC_W  = $clog2(SUM_W + 1);
   localparam int EQ_W   = ROUNDS_W + 1;

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RDW  = 5'd1;
   localparam logic [4:0] S_RESP = 5'd2;
   localparam logic [4:0] S_CLR  = 5'd3;
   localparam logic [4:0] S_RD   = 5'd4;
   localparam logic [4:0] S_SQ   = 5'd5;
   localparam logic [4:0] S_ACC  = 5'd6;
   localparam logic [4:0] S_CMP  = 5'd7;
   localparam logic [4:0] S_ADD  = 5'd8;
   localparam logic [4:0] S_AR   = 5'd9;
   localparam logic [4:0] S_AW   = 5'd10;
   localparam logic [4:0] S_UC   = 5'd11;
   localparam logic [4:0] S_UR   = 5'd12;
   localparam logic [4:0] S_UD   = 5'd13;
   localparam logic [4:0] S_DIV  = 5'd14;
   localparam logic [4:0] S_UW   = 5'd15;
   localparam logic [4:0] S_END  = 5'd16;

   // configuration registers
   logic [NSAMP_W-1:0]  ns_cfg_ff, ns_cfg_in;
   logic [NCENT_W-1:0]  nc_cfg_ff, nc_cfg_in;
   logic [NATTR_W-1:0]  na_cfg_ff, na_cfg_in;
   logic [ROUNDS_W-1:0] maxr_ff, maxr_in;
   logic [ROUNDS_W-1:0] stop_ff, stop_in;

   // control registers
   logic [4:0]          state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CLUSTER_W-1:0] rsp_cluster_ff, rsp_cluster_in;
   logic [VW-1:0]       rsp_cval_ff, rsp_cval_in;
   logic [ROUNDS_W-1:0] rsp_rounds_ff, rsp_rounds_in;
   logic                rsp_conv_ff, rsp_conv_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [SW-1:0]       rd_row_ff, rd_row_in;
   logic [CA_W-1:0]     rd_caddr_ff, rd_caddr_in;
   logic                rd_ok_ff, rd_ok_in;
   logic [SW-1:0]       ns_last_ff, ns_last_in;
   logic [CW-1:0]       nc_last_ff, nc_last_in;
   logic [AW-1:0]       na_last_ff, na_last_in;
   logic [SW-1:0]       i_ff, i_in;
   logic [CW-1:0]       c_ff, c_in;
   logic [AW-1:0]       a_ff, a_in;
   logic [CA_W-1:0]     clr_ff, clr_in;
   logic [P_W-1:0]      prod_ff, prod_in;
   logic [D_W-1:0]      d_ff, d_in;
   logic [D_W-1:0]      best_ff, best_in;
   logic [CW-1:0]       best_c_ff, best_c_in;
   logic [IS_W-1:0]     isum_ff, isum_in;
   logic [IS_W-1:0]     prev_ff, prev_in;
   logic [EQ_W-1:0]     eq_ff, eq_in;
   logic [ROUNDS_W-1:0] rc_ff, rc_in;
   logic                conv_ff, conv_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    cnt_ff [MAX_CLUSTERS];
   logic [CNT_W-1:0]    cnt_in [MAX_CLUSTERS];
   // serial divider
   logic                dv_neg_ff, dv_neg_in;
   logic [SUM_W-1:0]    dv_quo_ff, dv_quo_in;
   logic [CNT_W:0]      dv_rem_ff, dv_rem_in;
   logic [CNT_W-1:0]    dv_den_ff, dv_den_in;
   logic [DVC_W-1:0]    dv_step_ff, dv_step_in;

   // memories
   logic [VW-1:0]    sample_mem [SA_N];
   logic [VW-1:0]    centroid_mem [CA_N];
   logic [CI_W-1:0]  assign_mem [MAX_SAMPLES];
   logic [SUM_W-1:0] sums_mem [CA_N];
   logic [VW-1:0]    s_rdata_ff;
   logic [VW-1:0]    c_rdata_ff;
   logic [CI_W-1:0]  a_rdata_ff;
   logic [SUM_W-1:0] m_rdata_ff;

   // memory ports
   logic             s_we, c_we, a_we, m_we;
   logic [SA_W-1:0]  s_waddr, s_raddr;
   logic [CA_W-1:0]  c_waddr, c_raddr, m_addr;
   logic [VW-1:0]    s_wdata, c_wdata;
   logic [SUM_W-1:0] m_wdata;

   // handshakes
   logic req_xfer, rsp_free, cfg_write;
   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // configuration write and read
   always_comb begin
      ns_cfg_in = ns_cfg_ff;
      nc_cfg_in = nc_cfg_ff;
      na_cfg_in = na_cfg_ff;
      maxr_in   = maxr_ff;
      stop_in   = stop_ff;
      if (cfg_write) begin
         unique case (reg_idx_type'(csr_paddr[4:2]))
            REG_NUM_SAMPLES:   ns_cfg_in = csr_pwdata[NSAMP_W-1:0];
            REG_NUM_CENTROIDS: nc_cfg_in = csr_pwdata[NCENT_W-1:0];
            REG_NUM_ATTRS:     na_cfg_in = csr_pwdata[NATTR_W-1:0];
            REG_MAX_ROUNDS:    maxr_in   = csr_pwdata[ROUNDS_W-1:0];
            REG_STOP_COUNT:    stop_in   = csr_pwdata[ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx_type'(csr_paddr[4:2]))
         REG_NUM_SAMPLES:   csr_prdata = PDATA_W'(ns_cfg_ff);
         REG_NUM_CENTROIDS: csr_prdata = PDATA_W'(nc_cfg_ff);
         REG_NUM_ATTRS:     csr_prdata = PDATA_W'(na_cfg_ff);
         REG_MAX_ROUNDS:    csr_prdata = PDATA_W'(maxr_ff);
         REG_STOP_COUNT:    csr_prdata = PDATA_W'(stop_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // clamped counts for a run
   logic [31:0] ns_eff, nc_eff, na_eff;
   always_comb begin
      ns_eff = 32'(ns_cfg_ff);
      nc_eff = 32'(nc_cfg_ff);
      na_eff = 32'(na_cfg_ff);
      if (ns_eff == 32'd0) ns_eff = 32'd1;
      if (ns_eff > 32'(MAX_SAMPLES)) ns_eff = 32'(MAX_SAMPLES);
      if (nc_eff == 32'd0) nc_eff = 32'd1;
      if (nc_eff > 32'(MAX_CLUSTERS)) nc_eff = 32'(MAX_CLUSTERS);
      if (na_eff == 32'd0) na_eff = 32'd1;
      if (na_eff > 32'(MAX_ATTRS)) na_eff = 32'(MAX_ATTRS);
   end

   // request address decode
   logic row_s_ok, row_c_ok, col_ok;
   logic [SA_W-1:0] req_saddr;
   logic [CA_W-1:0] req_caddr;
   assign row_s_ok  = (32'(req_row) < 32'(MAX_SAMPLES));
   assign row_c_ok  = (32'(req_row) < 32'(MAX_CLUSTERS));
   assign col_ok    = (32'(req_column) < 32'(MAX_ATTRS));
   assign req_saddr = SA_W'(32'(req_row) * 32'(MAX_ATTRS) + 32'(req_column));
   assign req_caddr = CA_W'(32'(req_row) * 32'(MAX_ATTRS) + 32'(req_column));

   // working addresses
   logic [SA_W-1:0] s_addr_ia;
   logic [CA_W-1:0] c_addr_ca, c_addr_ba;
   assign s_addr_ia = SA_W'(32'(i_ff) * 32'(MAX_ATTRS) + 32'(a_ff));
   assign c_addr_ca = CA_W'(32'(c_ff) * 32'(MAX_ATTRS) + 32'(a_ff));
   assign c_addr_ba = CA_W'(32'(best_c_ff) * 32'(MAX_ATTRS) + 32'(a_ff));

   // shared arithmetic
   logic signed [VW:0]   diff;
   logic signed [P_W-1:0] sq;
   logic [CW-1:0]        cnt_sel;
   logic [CNT_W-1:0]     cnt_cur;
   logic [CNT_W:0]       dv_rem_sh;
   logic                 dv_ge;
   logic [SUM_W-1:0]     dv_q;
   logic [ROUNDS_W-1:0]  rc_nx;
   logic [EQ_W-1:0]      eq_nx;
   logic                 conv_nx;
   logic [IS_W-1:0]      isum_add;

   assign diff     = $signed({s_rdata_ff[VW-1], s_rdata_ff})
                   - $signed({c_rdata_ff[VW-1], c_rdata_ff});
   assign sq       = diff * diff;
   assign cnt_sel  = (state_ff == S_ADD) ? best_c_ff : c_ff;
   assign cnt_cur  = cnt_ff[cnt_sel];
   assign dv_rem_sh = {dv_rem_ff[CNT_W-1:0], dv_quo_ff[SUM_W-1]};
   assign dv_ge    = (dv_rem_sh >= {1'b0, dv_den_ff});
   assign dv_q     = dv_neg_ff ? (~dv_quo_ff + SUM_W'(1)) : dv_quo_ff;
   assign rc_nx    = rc_ff + ROUNDS_W'(1);
   assign eq_nx    = eq_ff + EQ_W'((rc_nx >= ROUNDS_W'(2)) && (isum_ff == prev_ff));
   assign conv_nx  = (rc_nx > ROUNDS_W'(2)) && (eq_nx > EQ_W'(stop_ff));
   assign isum_add = isum_ff + IS_W'(best_c_ff) + IS_W'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_cluster_in = rsp_cluster_ff;
      rsp_cval_in  = rsp_cval_ff;
      rsp_rounds_in = rsp_rounds_ff;
      rsp_conv_in  = rsp_conv_ff;
      kind_in      = kind_ff;
      rd_row_in    = rd_row_ff;
      rd_caddr_in  = rd_caddr_ff;
      rd_ok_in     = rd_ok_ff;
      ns_last_in   = ns_last_ff;
      nc_last_in   = nc_last_ff;
      na_last_in   = na_last_ff;
      i_in         = i_ff;
      c_in         = c_ff;
      a_in         = a_ff;
      clr_in       = clr_ff;
      prod_in      = prod_ff;
      d_in         = d_ff;
      best_in      = best_ff;
      best_c_in    = best_c_ff;
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      eq_in        = eq_ff;
      rc_in        = rc_ff;
      conv_in      = conv_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      dv_neg_in    = dv_neg_ff;
      dv_quo_in    = dv_quo_ff;
      dv_rem_in    = dv_rem_ff;
      dv_den_in    = dv_den_ff;
      dv_step_in   = dv_step_ff;
      s_we = 1'b0; s_waddr = req_saddr; s_wdata = req_value;
      c_we = 1'b0; c_waddr = req_caddr; c_wdata = req_value;
      a_we = 1'b0;
      m_we = 1'b0; m_wdata = '0;
      s_raddr = s_addr_ia;
      c_raddr = c_addr_ca;
      m_addr  = c_addr_ca;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               rd_row_in   = SW'(req_row);
               rd_caddr_in = req_caddr;
               case (cmd_type'(req_cmd))
                  CMD_LOAD_SAMPLE: s_we = row_s_ok && col_ok;
                  CMD_LOAD_CENTROID: c_we = row_c_ok && col_ok;
                  CMD_RUN: begin
                     kind_in    = KIND_RUN_DONE;
                     ns_last_in = SW'(ns_eff - 32'd1);
                     nc_last_in = CW'(nc_eff - 32'd1);
                     na_last_in = AW'(na_eff - 32'd1);
                     rc_in      = '0;
                     prev_in    = '0;
                     eq_in      = EQ_W'(1);
                     conv_in    = 1'b0;
                     clr_in     = '0;
                     state_in   = (maxr_ff == '0) ? S_RESP : S_CLR;
                  end
                  CMD_READ_ASSIGN: begin
                     kind_in  = KIND_ASSIGN;
                     rd_ok_in = row_s_ok && (CNT_W'(req_row) < fill_ff);
                     state_in = S_RDW;
                  end
                  CMD_READ_CENTROID: begin
                     kind_in  = KIND_CENTROID;
                     rd_ok_in = row_c_ok && col_ok;
                     state_in = S_RDW;
                  end
                  default: ;
               endcase
            end
         end
         S_RDW: begin
            c_raddr  = rd_caddr_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            c_raddr = rd_caddr_ff;
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = kind_ff;
               rsp_cluster_in = (kind_ff == KIND_ASSIGN && rd_ok_ff)
                              ? CLUSTER_W'(a_rdata_ff) : '0;
               rsp_cval_in    = (kind_ff == KIND_CENTROID && rd_ok_ff) ? c_rdata_ff : '0;
               rsp_rounds_in  = rc_ff;
               rsp_conv_in    = conv_ff;
               state_in       = S_IDLE;
            end
         end
         // clear the member sums, one entry a cycle
         S_CLR: begin
            m_addr = clr_ff;
            m_we   = 1'b1;
            clr_in = clr_ff + CA_W'(1);
            if (32'(clr_ff) == 32'(CA_N - 1)) begin
               for (int k = 0; k < MAX_CLUSTERS; k++) cnt_in[k] = '0;
               isum_in  = '0;
               i_in     = '0;
               c_in     = '0;
               a_in     = '0;
               d_in     = '0;
               state_in = S_RD;
            end
         end
         // distance: read, square, accumulate
         S_RD: state_in = S_SQ;
         S_SQ: begin
            prod_in  = P_W'(sq);
            state_in = S_ACC;
         end
         S_ACC: begin
            d_in = d_ff + D_W'(prod_ff);
            if (a_ff == na_last_ff) begin
               state_in = S_CMP;
            end else begin
               a_in     = a_ff + AW'(1);
               state_in = S_RD;
            end
         end
         // keep the first nearest centroid
         S_CMP: begin
            if (c_ff == '0 || d_ff < best_ff) begin
               best_in   = d_ff;
               best_c_in = c_ff;
            end
            a_in = '0;
            d_in = '0;
            if (c_ff == nc_last_ff) begin
               state_in = S_ADD;
            end else begin
               c_in     = c_ff + CW'(1);
               state_in = S_RD;
            end
         end
         S_ADD: begin
            a_we             = 1'b1;
            isum_in          = isum_add;
            cnt_in[best_c_ff] = cnt_cur + CNT_W'(1);
            if (CNT_W'(i_ff) + CNT_W'(1) > fill_ff) fill_in = CNT_W'(i_ff) + CNT_W'(1);
            a_in             = '0;
            state_in         = S_AR;
         end
         // member sums read-modify-write
         S_AR: begin
            m_addr   = c_addr_ba;
            state_in = S_AW;
         end
         S_AW: begin
            m_addr  = c_addr_ba;
            m_we    = 1'b1;
            m_wdata = m_rdata_ff + {{(SUM_W-VW){s_rdata_ff[VW-1]}}, s_rdata_ff};
            if (a_ff == na_last_ff) begin
               c_in = '0;
               a_in = '0;
               d_in = '0;
               if (i_ff == ns_last_ff) begin
                  state_in = S_UC;
               end else begin
                  i_in     = i_ff + SW'(1);
                  state_in = S_RD;
               end
            end else begin
               a_in     = a_ff + AW'(1);
               state_in = S_AR;
            end
         end
         // centroid update
         S_UC: begin
            a_in = '0;
            if (cnt_cur != '0) begin
               state_in = S_UR;
            end else if (c_ff == nc_last_ff) begin
               state_in = S_END;
            end else begin
               c_in = c_ff + CW'(1);
            end
         end
         S_UR: state_in = S_UD;
         S_UD: begin
            dv_neg_in  = m_rdata_ff[SUM_W-1];
            dv_quo_in  = m_rdata_ff[SUM_W-1] ? (~m_rdata_ff + SUM_W'(1)) : m_rdata_ff;
            dv_rem_in  = '0;
            dv_den_in  = cnt_cur;
            dv_step_in = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            dv_rem_in  = dv_ge ? (dv_rem_sh - {1'b0, dv_den_ff}) : dv_rem_sh;
            dv_quo_in  = {dv_quo_ff[SUM_W-2:0], dv_ge};
            dv_step_in = dv_step_ff + DVC_W'(1);
            if (32'(dv_step_ff) == 32'(SUM_W - 1)) state_in = S_UW;
         end
         S_UW: begin
            c_we    = 1'b1;
            c_waddr = c_addr_ca;
            c_wdata = dv_q[VW-1:0];
            if (a_ff == na_last_ff) begin
               a_in = '0;
               if (c_ff == nc_last_ff) begin
                  state_in = S_END;
               end else begin
                  c_in     = c_ff + CW'(1);
                  state_in = S_UC;
               end
            end else begin
               a_in     = a_ff + AW'(1);
               state_in = S_UR;
            end
         end
         // round bookkeeping and stop rule
         S_END: begin
            rc_in   = rc_nx;
            eq_in   = eq_nx;
            prev_in = isum_ff;
            conv_in = conv_nx;
            clr_in  = '0;
            state_in = (rc_nx < maxr_ff && !conv_nx) ? S_CLR : S_RESP;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ns_cfg_ff    <= NSAMP_W'(1);
         nc_cfg_ff    <= NCENT_W'(2);
         na_cfg_ff    <= NATTR_W'(1);
         maxr_ff      <= ROUNDS_W'(100);
         stop_ff      <= ROUNDS_W'(3);
         rc_ff        <= '0;
         conv_ff      <= 1'b0;
         prev_ff      <= '0;
         eq_ff        <= EQ_W'(1);
         fill_ff      <= '0;
         for (int k = 0; k < MAX_CLUSTERS; k++) cnt_ff[k] <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ns_cfg_ff    <= ns_cfg_in;
         nc_cfg_ff    <= nc_cfg_in;
         na_cfg_ff    <= na_cfg_in;
         maxr_ff      <= maxr_in;
         stop_ff      <= stop_in;
         rc_ff        <= rc_in;
         conv_ff      <= conv_in;
         prev_ff      <= prev_in;
         eq_ff        <= eq_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_cluster_ff <= rsp_cluster_in;
      rsp_cval_ff    <= rsp_cval_in;
      rsp_rounds_ff  <= rsp_rounds_in;
      rsp_conv_ff    <= rsp_conv_in;
      kind_ff        <= kind_in;
      rd_row_ff      <= rd_row_in;
      rd_caddr_ff    <= rd_caddr_in;
      rd_ok_ff       <= rd_ok_in;
      ns_last_ff     <= ns_last_in;
      nc_last_ff     <= nc_last_in;
      na_last_ff     <= na_last_in;
      i_ff           <= i_in;
      c_ff           <= c_in;
      a_ff           <= a_in;
      clr_ff         <= clr_in;
      prod_ff        <= prod_in;
      d_ff           <= d_in;
      best_ff        <= best_in;
      best_c_ff      <= best_c_in;
      isum_ff        <= isum_in;
      dv_neg_ff      <= dv_neg_in;
      dv_quo_ff      <= dv_quo_in;
      dv_rem_ff      <= dv_rem_in;
      dv_den_ff      <= dv_den_in;
      dv_step_ff     <= dv_step_in;
   end

   // sample store
   always_ff @(posedge clock) begin
      if (s_we) sample_mem[s_waddr] <= s_wdata;
      s_rdata_ff <= sample_mem[s_raddr];
   end

   // centroid store
   always_ff @(posedge clock) begin
      if (c_we) centroid_mem[c_waddr] <= c_wdata;
      c_rdata_ff <= centroid_mem[c_raddr];
   end

   // assignment store, valid below the fill mark
   always_ff @(posedge clock) begin
      if (a_we) assign_mem[i_ff] <= CI_W'(best_c_ff) + CI_W'(1);
      a_rdata_ff <= assign_mem[rd_row_ff];
   end

   // member sums
   always_ff @(posedge clock) begin
      if (m_we) sums_mem[m_addr] <= m_wdata;
      m_rdata_ff <= sums_mem[m_addr];
   end

   // outputs
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_cluster        = rsp_cluster_ff;
   assign rsp_centroid_value = rsp_cval_ff;
   assign rsp_rounds_run     = rsp_rounds_ff;
   assign rsp_converged      = rsp_conv_ff;

   // checks
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> dv_den_ff != '0)
      else $error("divider started with an empty cluster");

   a_conv_rounds: assert property (@(posedge clock) disable iff (reset)
      conv_ff |-> rc_ff > ROUNDS_W'(2))
      else $error("converged before the third round");

   a_best_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD |-> best_c_ff <= nc_last_ff)
      else $error("assigned cluster out of range");

endmodule
